// ===== sv/lzc_pkg.sv =====
// Shared constants and types for the LZ77 hash-chain coder.
`default_nettype none
package lzc_pkg;
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int MAX_MATCH_DEF = 32;
	localparam int HASH_BITS_DEF = 15;
	localparam int RING_DEPTH_DEF = 8192;
	localparam int MIN_MATCH = 3;

	localparam int POS_W = 32;
	localparam int DIST_W = 13;
	localparam int LEN_W = 6;
	localparam int EPOCH_W = 4;
	localparam int PADDR_W = 3;

	localparam logic [PADDR_W-1:0] ADDR_MAX_DISTANCE = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_MAX_LENGTH = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       code;
	} item_t;

	typedef struct packed {
		logic              is_match;
		logic [7:0]        literal_value;
		logic [DIST_W-1:0] match_distance;
		logic [LEN_W-1:0]  match_length;
		logic              last_in_run;
		logic              end_of_stream;
	} token_t;

	typedef struct packed {
		logic [DIST_W-1:0] max_dist;
		logic [LEN_W-1:0]  max_len;
	} limits_t;
endpackage
`default_nettype wire

// ===== sv/lzc_if.sv =====
// Stream interfaces for input bytes and output tokens.
`default_nettype none
interface lzc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzc_out_if;
	logic                      valid;
	logic                      ready;
	logic                      is_match;
	logic [7:0]                literal_value;
	logic [lzc_pkg::DIST_W-1:0] match_distance;
	logic [lzc_pkg::LEN_W-1:0]  match_length;
	logic                      last_in_run;
	logic                      end_of_stream;
	modport source(output valid, output is_match, output literal_value,
		output match_distance, output match_length, output last_in_run,
		output end_of_stream, input ready);
	modport sink(input valid, input is_match, input literal_value,
		input match_distance, input match_length, input last_in_run,
		input end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== sv/lz77_hash_chain_compressor.sv =====
// Top level: register port, byte front end and coding back end.
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          data_byte, last_byte
//  out_ch   out  valid/ready          is_match, literal_value, match_distance,
//                                     match_length, last_in_run, end_of_stream
//  apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// A byte is taken from the queue while the back end is idle. A coded position hashes
// three bytes, reads its head and walks the chain, comparing bytes up to the length cap
// (dual-port history read); a position inside a match is only inserted in the chain.
// After reset, and after every fifteenth stream end, the hash heads are swept, taking
// no bytes. A stalled output holds the back end only once the next token is ready.
`default_nettype none
module lz77_hash_chain_compressor #(
	parameter int WINDOW_SIZE = lzc_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_MATCH = lzc_pkg::MAX_MATCH_DEF,
	parameter int HASH_BITS = lzc_pkg::HASH_BITS_DEF,
	parameter int RING_DEPTH = lzc_pkg::RING_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lzc_in_if.sink                           in_ch,
	lzc_out_if.source                        out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lzc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	localparam int RING_CAP = RING_DEPTH - MAX_MATCH - 2;
	localparam int DIST_CAP = (WINDOW_SIZE < RING_CAP) ? WINDOW_SIZE : RING_CAP;
	localparam int DW = lzc_pkg::DIST_W;
	localparam int LW = lzc_pkg::LEN_W;

	logic [DW-1:0]    max_distance_q;
	logic [LW-1:0]    max_length_q;
	lzc_pkg::limits_t lim;
	lzc_pkg::item_t   item;
	lzc_pkg::token_t  tok;
	logic             item_valid, item_pop, tok_valid;
	logic             wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= DW'(4096);
			max_length_q <= LW'(32);
		end else if (wr) begin
			unique case (paddr)
				lzc_pkg::ADDR_MAX_DISTANCE: max_distance_q <= pwdata[DW-1:0];
				lzc_pkg::ADDR_MAX_LENGTH:   max_length_q <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			lzc_pkg::ADDR_MAX_DISTANCE: prdata = {{(32-DW){1'b0}}, max_distance_q};
			lzc_pkg::ADDR_MAX_LENGTH:   prdata = {{(32-LW){1'b0}}, max_length_q};
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		lim.max_dist = (32'(max_distance_q) > DIST_CAP) ? DW'(DIST_CAP) : max_distance_q;
		lim.max_len = (32'(max_length_q) > MAX_MATCH) ? LW'(MAX_MATCH) : max_length_q;
	end

	lzc_front #(.MAX_MATCH(MAX_MATCH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.item(item),
		.item_valid(item_valid),
		.item_pop(item_pop)
	);

	lzc_back #(.HASH_BITS(HASH_BITS), .RING_DEPTH(RING_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_pop(item_pop),
		.lim(lim),
		.tok(tok),
		.tok_valid(tok_valid),
		.tok_ready(out_ch.ready)
	);

	assign out_ch.valid = tok_valid;
	assign out_ch.is_match = tok.is_match;
	assign out_ch.literal_value = tok.literal_value;
	assign out_ch.match_distance = tok.match_distance;
	assign out_ch.match_length = tok.match_length;
	assign out_ch.last_in_run = tok.last_in_run;
	assign out_ch.end_of_stream = tok.end_of_stream;
endmodule
`default_nettype wire

// ===== sv/lzc_front.sv =====
// Input side: takes bytes, tags those that release a coding step, queues them.
`default_nettype none
module lzc_front #(
	parameter int MAX_MATCH = lzc_pkg::MAX_MATCH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	lzc_in_if.sink              in_ch,
	output lzc_pkg::item_t      item,
	output logic                item_valid,
	input  wire logic           item_pop
);
	localparam int LOOKAHEAD = MAX_MATCH + 2;
	localparam int CNT_W = $clog2(LOOKAHEAD);
	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam logic [CNT_W-1:0] SEEN_FULL = CNT_W'(LOOKAHEAD - 1);

	lzc_pkg::item_t   fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic [CNT_W-1:0] seen_q;
	logic             push, pop;
	lzc_pkg::item_t   new_item;

	assign in_ch.ready = fill_q != (PTR_W+1)'(DEPTH);
	assign push = in_ch.valid & in_ch.ready;
	assign item_valid = fill_q != '0;
	assign pop = item_pop & item_valid;
	assign item = fifo_q[rd_ptr_q];

	// coder trails the input by the lookahead, so a byte codes once the window is full
	always_comb begin
		new_item.data_byte = in_ch.data_byte;
		new_item.last_byte = in_ch.last_byte;
		new_item.code = seen_q == SEEN_FULL;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			seen_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (in_ch.last_byte) begin
					seen_q <= '0;
				end else if (seen_q != SEEN_FULL) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/lzc_back.sv =====
// Coding side: history ring, hash heads, chain walk, token output register.
`default_nettype none
module lzc_back #(
	parameter int HASH_BITS = lzc_pkg::HASH_BITS_DEF,
	parameter int RING_DEPTH = lzc_pkg::RING_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lzc_pkg::item_t   item,
	input  wire logic             item_valid,
	output logic                  item_pop,
	input  wire lzc_pkg::limits_t lim,
	output lzc_pkg::token_t       tok,
	output logic                  tok_valid,
	input  wire logic             tok_ready
);
	localparam int RA_W = $clog2(RING_DEPTH);
	localparam int HASH_COUNT = 1 << HASH_BITS;
	localparam int PW = lzc_pkg::POS_W;
	localparam int EW = lzc_pkg::EPOCH_W;
	localparam int HE_W = EW + PW;
	localparam int CH_W = PW + 1;
	localparam int LW = lzc_pkg::LEN_W;
	localparam int DW = lzc_pkg::DIST_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_POS, S_H1, S_H2, S_HEAD, S_WALK, S_CMP_RD,
		S_CMP_CHK, S_CAND, S_CHAIN, S_INSERT, S_TOKEN, S_NEXT, S_END
	} state_t;

	logic [7:0]      ring_mem [RING_DEPTH];
	logic [HE_W-1:0] head_mem [HASH_COUNT];
	logic [CH_W-1:0] chain_mem [RING_DEPTH];

	logic [7:0]      rda_q, rdb_q;
	logic [HE_W-1:0] head_rd_q;
	logic [CH_W-1:0] chain_rd_q;

	logic [RA_W-1:0]      ra_addr, rb_addr, chain_raddr;
	logic [HASH_BITS-1:0] head_raddr;
	logic                 ring_we, head_we, chain_we;
	logic [RA_W-1:0]      ring_waddr, chain_waddr;
	logic [HASH_BITS-1:0] head_waddr;
	logic [HE_W-1:0]      head_wdata;

	state_t               state_q;
	logic [PW-1:0]        n_q, p_q, hp_q, c_q;
	logic [LW-1:0]        skip_q, len_q, cap_q, best_q;
	logic [DW-1:0]        bestd_q;
	logic                 flush_q, ins_only_q, lit_only_q, hv_q, v_q;
	logic [EW-1:0]        epoch_q;
	logic [HASH_BITS-1:0] clr_q, h_q;
	logic [7:0]           b0_q, b1_q;
	lzc_pkg::token_t      tok_q;
	logic                 tok_valid_q;

	logic [PW-1:0] left, d, adv_pos;
	logic [17:0]   t1, t2;
	logic          is_lit, fin, slot_free, tok_load;
	lzc_pkg::token_t new_tok;

	assign left = n_q - p_q;
	assign d = p_q - c_q;
	// h*31 + c, twice, as shift and subtract
	assign t1 = ({10'b0, b0_q} << 5) - {10'b0, b0_q} + {10'b0, b1_q};
	assign t2 = (t1 << 5) - t1 + {10'b0, rda_q};
	assign is_lit = lit_only_q || (best_q < LW'(lzc_pkg::MIN_MATCH));
	assign adv_pos = p_q + (is_lit ? PW'(1) : PW'(best_q));
	assign fin = adv_pos == n_q;
	assign slot_free = !tok_valid_q || tok_ready;
	assign tok_load = (state_q == S_TOKEN) && slot_free;
	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign tok = tok_q;
	assign tok_valid = tok_valid_q;

	always_comb begin
		new_tok.is_match = !is_lit;
		new_tok.literal_value = is_lit ? b0_q : 8'd0;
		new_tok.match_distance = is_lit ? '0 : bestd_q;
		new_tok.match_length = is_lit ? '0 : best_q;
		new_tok.last_in_run = flush_q ? fin : 1'b1;
		new_tok.end_of_stream = flush_q && fin;
	end

	always_comb begin
		ra_addr = p_q[RA_W-1:0];
		rb_addr = RA_W'(p_q + PW'(1));
		unique case (state_q)
			S_H1: ra_addr = RA_W'(p_q + PW'(2));
			S_CMP_RD: begin
				ra_addr = RA_W'(c_q + PW'(len_q));
				rb_addr = RA_W'(p_q + PW'(len_q));
			end
			default: ;
		endcase
		head_raddr = t2[HASH_BITS-1:0];
		chain_raddr = c_q[RA_W-1:0];

		ring_we = item_pop;
		ring_waddr = n_q[RA_W-1:0];
		chain_we = state_q == S_INSERT;
		chain_waddr = p_q[RA_W-1:0];
		head_we = (state_q == S_INSERT) || (state_q == S_CLEAR);
		head_waddr = (state_q == S_CLEAR) ? clr_q : h_q;
		head_wdata = (state_q == S_CLEAR) ? '0 : {epoch_q, p_q};
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= item.data_byte;
		end
		rda_q <= ring_mem[ra_addr];
		rdb_q <= ring_mem[rb_addr];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[chain_waddr] <= {hv_q, hp_q};
		end
		chain_rd_q <= chain_mem[chain_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			n_q <= '0;
			p_q <= '0;
			skip_q <= '0;
			flush_q <= 1'b0;
			epoch_q <= EW'(1);
			clr_q <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			if (tok_load) begin
				tok_valid_q <= 1'b1;
			end else if (tok_ready) begin
				tok_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HASH_BITS'(HASH_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						n_q <= n_q + 1'b1;
						if (item.last_byte) begin
							flush_q <= 1'b1;
							state_q <= S_NEXT;
						end else if (item.code) begin
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					best_q <= '0;
					bestd_q <= '0;
					cap_q <= (left < PW'(lim.max_len)) ? left[LW-1:0] : lim.max_len;
					ins_only_q <= (skip_q != '0) && (left > PW'(2));
					lit_only_q <= (skip_q == '0) && (left <= PW'(2));
					if (skip_q != '0) begin
						skip_q <= skip_q - 1'b1;
						if (left > PW'(2)) begin
							state_q <= S_H1;
						end else begin
							p_q <= p_q + 1'b1;
							state_q <= S_NEXT;
						end
					end else begin
						state_q <= S_H1;
					end
				end
				S_H1: begin
					b0_q <= rda_q;
					b1_q <= rdb_q;
					state_q <= lit_only_q ? S_TOKEN : S_H2;
				end
				S_H2: begin
					h_q <= t2[HASH_BITS-1:0];
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					hv_q <= head_rd_q[HE_W-1 -: EW] == epoch_q;
					v_q <= head_rd_q[HE_W-1 -: EW] == epoch_q;
					hp_q <= head_rd_q[PW-1:0];
					c_q <= head_rd_q[PW-1:0];
					state_q <= ins_only_q ? S_INSERT : S_WALK;
				end
				S_WALK: begin
					len_q <= '0;
					if (!v_q || d == '0 || d > PW'(lim.max_dist)) begin
						state_q <= S_INSERT;
					end else begin
						state_q <= S_CMP_RD;
					end
				end
				S_CMP_RD: state_q <= (len_q < cap_q) ? S_CMP_CHK : S_CAND;
				S_CMP_CHK: begin
					if (rda_q == rdb_q) begin
						len_q <= len_q + 1'b1;
						state_q <= S_CMP_RD;
					end else begin
						state_q <= S_CAND;
					end
				end
				S_CAND: begin
					// strict compare: a tie keeps the nearer candidate
					if (len_q > best_q) begin
						best_q <= len_q;
						bestd_q <= d[DW-1:0];
					end
					state_q <= S_CHAIN;
				end
				S_CHAIN: begin
					v_q <= chain_rd_q[PW];
					c_q <= chain_rd_q[PW-1:0];
					state_q <= S_WALK;
				end
				S_INSERT: begin
					if (ins_only_q) begin
						p_q <= p_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_TOKEN;
					end
				end
				S_TOKEN: begin
					if (slot_free) begin
						tok_q <= new_tok;
						p_q <= p_q + 1'b1;
						if (!is_lit) begin
							skip_q <= best_q - 1'b1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (!flush_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= (p_q == n_q) ? S_END : S_POS;
					end
				end
				S_END: begin
					n_q <= '0;
					p_q <= '0;
					skip_q <= '0;
					flush_q <= 1'b0;
					// heads are stale once their epoch differs; sweep when the mark runs out
					if (epoch_q == '1) begin
						epoch_q <= EW'(1);
						clr_q <= '0;
						state_q <= S_CLEAR;
					end else begin
						epoch_q <= epoch_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
